>>> hdl/ffba_pkg.sv
// ffba_pkg: shared constants, codes and types of the first-fit block allocator
// no dependencies; imported by first_fit_block_allocator_unit

package ffba_pkg;

    localparam int CELLS_DEF   = 128;
    localparam int ID_BITS_DEF = 16;

    localparam int CFG_W      = 8;
    localparam int MODE_W     = 2;
    localparam int SIZE_W     = 8;
    localparam int EID_W      = 16;
    localparam int STATUS_W   = 2;
    localparam int BID_W      = 16;
    localparam int IN_TDATA_W = 24;   // alloc_size + erase_id, already whole bytes
    localparam int OUT_TDATA_W = 16;

    localparam logic [CFG_W-1:0] CFG_RESET = 8'd128;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC  = 2'd0,
        MODE_ERASE  = 2'd1,
        MODE_DEFRAG = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FAIL    = 2'd1,
        ST_ILLEGAL = 2'd2,
        ST_SPARE   = 2'd3
    } t_status;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CLEAR = 6'b000010,
        S_SCAN  = 6'b000100,
        S_FILL  = 6'b001000,
        S_ZERO  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

endpackage

>>> hdl/first_fit_block_allocator_unit.sv
// first_fit_block_allocator_unit: first-fit cell allocator with erase and compaction
// owner store is one synchronous single-port-write memory; depends on ffba_pkg
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+-----------------------------------
//  s_axis    | in        | i_s_axis_tvalid/o_..tready | tuser: mode; tdata: size, erase id
//  m_axis    | out       | o_m_axis_tvalid/i_..tready | tuser: status; tdata: block id
//  cfg       | in        | i_cfg_valid/o_cfg_ready    | cells in use (always ready)
//
// one request at a time; m = managed cells. each request walks the owner memory
// at most once through its one read port: allocate stops at the first free run that
// fits and fills it, erase and defragment read all m cells, immediate answers skip it.
// after reset a clearing pass zeroes every cell of the memory; no item is taken
// meanwhile. the result register lets a new item in while a result waits; a
// finished request holds in its last state while the result register is full.

module first_fit_block_allocator_unit #(
    parameter int CELLS   = ffba_pkg::CELLS_DEF,
    parameter int ID_BITS = ffba_pkg::ID_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ffba_pkg::CFG_W-1:0]        i_cfg_data,
    // request stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [ffba_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,  // [7:0] alloc_size, [23:8] erase_id
    input  logic [ffba_pkg::MODE_W-1:0]       i_s_axis_tuser,  // [1:0] mode
    // result stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [ffba_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,  // [15:0] block_id
    output logic [ffba_pkg::STATUS_W-1:0]     o_m_axis_tuser   // [1:0] status
);

    import ffba_pkg::*;

    localparam int AW  = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CW  = $clog2(CELLS + 1);
    localparam int RW  = (CW > SIZE_W) ? CW : SIZE_W;
    localparam int XW  = (ID_BITS > EID_W) ? ID_BITS : EID_W;
    localparam logic [31:0] CELLS_W = 32'(CELLS);

    // owner memory
    logic [ID_BITS-1:0] r_mem [CELLS];
    logic [ID_BITS-1:0] r_rdata;
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [ID_BITS-1:0] w_wdata;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_addr, n_addr;
    logic                r_pvld, n_pvld;
    logic [AW-1:0]       r_paddr, n_paddr;
    logic [CW-1:0]       r_m, n_m;
    t_mode               r_mode, n_mode;
    logic [SIZE_W-1:0]   r_size, n_size;
    logic [EID_W-1:0]    r_eid, n_eid;
    logic [CW-1:0]       r_run, n_run;
    logic [AW-1:0]       r_start, n_start;
    logic [AW-1:0]       r_end, n_end;
    logic [AW-1:0]       r_waddr, n_waddr;
    logic [CW-1:0]       r_dst, n_dst;
    logic                r_hit, n_hit;
    logic [ID_BITS-1:0]  r_next_id, n_next_id;
    t_status             r_res_st, n_res_st;
    logic [BID_W-1:0]    r_res_id, n_res_id;
    logic                r_out_vld, n_out_vld;
    t_status             r_out_st, n_out_st;
    logic [BID_W-1:0]    r_out_id, n_out_id;
    logic [CFG_W-1:0]    r_cfg;

    logic                in_acc;
    logic [CW-1:0]       m_now;
    logic [SIZE_W-1:0]   in_size;
    logic [EID_W-1:0]    in_eid;
    t_mode               in_mode;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_id;
    assign o_m_axis_tuser  = r_out_st;

    assign in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign in_size = i_s_axis_tdata[SIZE_W-1:0];
    assign in_eid  = i_s_axis_tdata[SIZE_W +: EID_W];
    assign in_mode = t_mode'(i_s_axis_tuser);

    always_comb begin
        if (32'(r_cfg) > CELLS_W) begin
            m_now = CW'(CELLS);
        end else begin
            m_now = CW'(r_cfg);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[r_addr[AW-1:0]];
    end

    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_pvld    = 1'b0;
        n_paddr   = r_paddr;
        n_m       = r_m;
        n_mode    = r_mode;
        n_size    = r_size;
        n_eid     = r_eid;
        n_run     = r_run;
        n_start   = r_start;
        n_end     = r_end;
        n_waddr   = r_waddr;
        n_dst     = r_dst;
        n_hit     = r_hit;
        n_next_id = r_next_id;
        n_res_st  = r_res_st;
        n_res_id  = r_res_id;
        n_out_vld = r_out_vld && !i_m_axis_tready;
        n_out_st  = r_out_st;
        n_out_id  = r_out_id;
        w_we      = 1'b0;
        w_waddr   = r_waddr;
        w_wdata   = '0;

        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_addr[AW-1:0];
                if (32'(r_addr) == CELLS_W - 32'd1) begin
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_mode   = in_mode;
                    n_size   = in_size;
                    n_eid    = in_eid;
                    n_m      = m_now;
                    n_addr   = '0;
                    n_run    = '0;
                    n_dst    = '0;
                    n_hit    = 1'b0;
                    n_res_id = '0;
                    n_res_st = ST_OK;
                    n_state  = S_SCAN;
                    case (in_mode)
                        MODE_ALLOC: begin
                            if (in_size == '0 || r_next_id == '1) begin
                                n_res_st = ST_FAIL;
                                n_state  = S_DONE;
                            end
                        end
                        MODE_ERASE: begin
                            if (in_eid == '0) begin
                                n_res_st = ST_ILLEGAL;
                                n_state  = S_DONE;
                            end
                        end
                        MODE_DEFRAG: begin
                            n_state = S_SCAN;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // the compare stage sees each read in the cycle after it is issued
                if (r_addr < r_m) begin
                    n_pvld  = 1'b1;
                    n_paddr = r_addr[AW-1:0];
                    n_addr  = r_addr + 1'b1;
                end
                if (r_pvld) begin
                    case (r_mode)
                        MODE_ALLOC: begin
                            if (r_rdata != '0) begin
                                n_run = '0;
                            end else begin
                                n_run = r_run + 1'b1;
                                if (r_run == '0) begin
                                    n_start = r_paddr;
                                end
                                if (RW'(r_run) + RW'(1) == RW'(r_size)) begin
                                    n_waddr = (r_run == '0) ? r_paddr : r_start;
                                    n_end   = r_paddr;
                                    n_pvld  = 1'b0;
                                    n_state = S_FILL;
                                end
                            end
                        end
                        MODE_ERASE: begin
                            if (XW'(r_rdata) == XW'(r_eid)) begin
                                w_we    = 1'b1;
                                w_waddr = r_paddr;
                                n_hit   = 1'b1;
                            end
                        end
                        default: begin
                            // compaction: owned cells go to the write pointer
                            if (r_rdata != '0) begin
                                w_we    = 1'b1;
                                w_waddr = r_dst[AW-1:0];
                                w_wdata = r_rdata;
                                n_dst   = r_dst + 1'b1;
                            end
                        end
                    endcase
                end else if (!(r_addr < r_m)) begin
                    case (r_mode)
                        MODE_ALLOC: begin
                            n_res_st = ST_FAIL;
                            n_state  = S_DONE;
                        end
                        MODE_ERASE: begin
                            n_res_st = r_hit ? ST_OK : ST_ILLEGAL;
                            n_state  = S_DONE;
                        end
                        default: begin
                            n_state = S_ZERO;
                        end
                    endcase
                end
            end
            S_FILL: begin
                w_we    = 1'b1;
                w_waddr = r_waddr;
                w_wdata = r_next_id;
                if (r_waddr == r_end) begin
                    n_res_st  = ST_OK;
                    n_res_id  = BID_W'(r_next_id);
                    n_next_id = r_next_id + 1'b1;
                    n_state   = S_DONE;
                end else begin
                    n_waddr = r_waddr + 1'b1;
                end
            end
            S_ZERO: begin
                if (r_dst < r_m) begin
                    w_we    = 1'b1;
                    w_waddr = r_dst[AW-1:0];
                    n_dst   = r_dst + 1'b1;
                end else begin
                    n_res_st = ST_OK;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_vld || i_m_axis_tready) begin
                    n_out_vld = 1'b1;
                    n_out_st  = r_res_st;
                    n_out_id  = r_res_id;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_addr    <= '0;
            r_pvld    <= 1'b0;
            r_next_id <= ID_BITS'(1);
            r_out_vld <= 1'b0;
            r_cfg     <= CFG_RESET;
        end else begin
            r_state   <= n_state;
            r_addr    <= n_addr;
            r_pvld    <= n_pvld;
            r_next_id <= n_next_id;
            r_out_vld <= n_out_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_paddr  <= n_paddr;
        r_m      <= n_m;
        r_mode   <= n_mode;
        r_size   <= n_size;
        r_eid    <= n_eid;
        r_run    <= n_run;
        r_start  <= n_start;
        r_end    <= n_end;
        r_waddr  <= n_waddr;
        r_dst    <= n_dst;
        r_hit    <= n_hit;
        r_res_st <= n_res_st;
        r_res_id <= n_res_id;
        r_out_st <= n_out_st;
        r_out_id <= n_out_id;
    end

    // a scan write must land behind the read pointer, never on a cell still to be read
    a_scan_write_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && w_we) |-> (CW'(w_waddr) < r_addr))
        else $error("scan write ahead of read pointer");

    a_next_id_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next_id != '0))
        else $error("identifier counter reached zero");

    a_id_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL && n_state == S_DONE) |=> (r_next_id == $past(r_next_id) + 1'b1))
        else $error("identifier counter did not advance after allocation");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_state == S_DONE))
        else $error("result raised outside completion");

endmodule
